/* src/b32d_pkg.sv */
// Package for the base32 stream decoder: result codes, character constants, digit decode.
package b32d_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 5;
  localparam int unsigned ACC_W   = 12;
  localparam int unsigned HELD_W  = 3;
  localparam int unsigned KIND_W  = 2;

  localparam logic [7:0] LIMIT_RESET = 8'd10;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CH_EIGHT = 8'h38;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
  localparam logic [CHAR_W-1:0] CH_UP_L  = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_UP_O  = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

  localparam logic [CHAR_W-1:0] LETTER_MASK = 8'h1F;
  localparam logic [CHAR_W-1:0] DIGIT_BASE  = 8'd26;

  typedef struct packed {
    logic                 skip;
    logic                 bad;
    logic [DIGIT_W-1:0]   val;
  } digit_t;

  function automatic digit_t decode_char(input logic [CHAR_W-1:0] c_in);
    digit_t             d;
    logic [CHAR_W-1:0]  c;
    logic [CHAR_W-1:0]  t;
    d = '0;
    c = c_in;
    t = '0;
    if (c_in == CH_SPACE || c_in == CH_TAB || c_in == CH_CR ||
        c_in == CH_LF || c_in == CH_DASH) begin
      d.skip = 1'b1;
    end else begin
      // common typos
      if (c_in == CH_ZERO) c = CH_UP_O;
      else if (c_in == CH_ONE) c = CH_UP_L;
      else if (c_in == CH_EIGHT) c = CH_UP_B;
      if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) begin
        t = (c & LETTER_MASK) - 8'd1;
        d.val = t[DIGIT_W-1:0];
      end else if (c >= CH_TWO && c <= CH_SEVEN) begin
        t = c - CH_TWO + DIGIT_BASE;
        d.val = t[DIGIT_W-1:0];
      end else begin
        d.bad = 1'b1;
      end
    end
    return d;
  endfunction

endpackage

/* src/base32_stream_decoder.sv */
// Base32 stream decoder top level: input register, decode/accumulate logic, result register.
//
// One character per request comes in on the in_ channel, and decoded bytes and
// end-of-string status go out on the out_ channel. Space, tab, CR, LF and dash
// are skipped; 0, 1 and 8 are read as O, L and B; letters of either case give
// 0..25 and digits 2..7 give 26..31. Each digit shifts five bits into a small
// accumulator and a byte result (kind 0) leaves as soon as eight bits are held.
// Once out_limit bytes have been produced for a string, further characters are
// dropped silently. An invalid character latches an error, produces nothing,
// and every character after it is dropped until the end request. A request with
// in_end_of_text set ignores its character and always yields one status
// result with out_final_res high: kind 1 with the byte count, or kind 2 on
// error; then all string state clears (out_limit keeps its value). Leftover
// bits below eight are dropped at the end. Rate: one request per cycle while
// the result register is free or draining. An accepted request waits in the
// input register, and its result then loads into the result register. Both
// channels stall independently; the input register lets one more request in
// while a result waits to be taken. cfg_wr_en writes out_limit (reset 10) and is
// meant to be used only while the block is idle.
module base32_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // character requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_text,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_byte_count,
  output logic       out_final_res
);

  localparam int unsigned SUM_W = b32d_pkg::HELD_W + 1;

  // config
  logic [7:0] out_limit_r;

  // input register
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_eot_r;

  // string state
  logic [b32d_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [b32d_pkg::HELD_W-1:0] held_r, held_nxt;
  logic [7:0]                  bytes_done_r, bytes_done_nxt;
  logic                        error_seen_r, error_seen_nxt;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic [7:0]  out_count_r, out_count_nxt;
  logic        out_final_r, out_final_nxt;
  logic        has_result;

  logic                         proc;
  b32d_pkg::digit_t             dig;
  logic [b32d_pkg::ACC_W-1:0]   acc_shift;
  logic [SUM_W-1:0]             held_sum;
  logic [SUM_W-1:0]             held_left;
  logic [b32d_pkg::ACC_W-1:0]   acc_byte;
  logic [b32d_pkg::ACC_W-1:0]   keep_mask;

  // stage advances when the result register is free or draining
  assign proc     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || proc;

  assign dig       = b32d_pkg::decode_char(in_char_r);
  assign acc_shift = {acc_r[b32d_pkg::ACC_W-b32d_pkg::DIGIT_W-1:0], dig.val};
  assign held_sum  = SUM_W'(held_r) + SUM_W'(b32d_pkg::DIGIT_W);
  assign held_left = held_sum - SUM_W'(8);
  assign acc_byte  = acc_shift >> held_left;
  assign keep_mask = (b32d_pkg::ACC_W'(1) << held_left) - b32d_pkg::ACC_W'(1);

  always_comb begin
    acc_nxt        = acc_r;
    held_nxt       = held_r;
    bytes_done_nxt = bytes_done_r;
    error_seen_nxt = error_seen_r;
    has_result     = 1'b0;
    out_kind_nxt   = b32d_pkg::KIND_BYTE;
    out_data_nxt   = '0;
    out_count_nxt  = '0;
    out_final_nxt  = 1'b0;
    if (in_eot_r) begin
      // status result, then clear the string
      has_result     = 1'b1;
      out_final_nxt  = 1'b1;
      if (error_seen_r) begin
        out_kind_nxt = b32d_pkg::KIND_ERROR;
      end else begin
        out_kind_nxt  = b32d_pkg::KIND_COUNT;
        out_count_nxt = bytes_done_r;
      end
      acc_nxt        = '0;
      held_nxt       = '0;
      bytes_done_nxt = '0;
      error_seen_nxt = 1'b0;
    end else if (!error_seen_r && (bytes_done_r < out_limit_r) && !dig.skip) begin
      if (dig.bad) begin
        error_seen_nxt = 1'b1;
      end else if (held_sum >= SUM_W'(8)) begin
        has_result     = 1'b1;
        out_data_nxt   = acc_byte[7:0];
        acc_nxt        = acc_shift & keep_mask;
        held_nxt       = held_left[b32d_pkg::HELD_W-1:0];
        bytes_done_nxt = bytes_done_r + 8'd1;
      end else begin
        acc_nxt  = acc_shift;
        held_nxt = held_sum[b32d_pkg::HELD_W-1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r  <= b32d_pkg::LIMIT_RESET;
      in_valid_r   <= 1'b0;
      acc_r        <= '0;
      held_r       <= '0;
      bytes_done_r <= '0;
      error_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        out_limit_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (proc) begin
        acc_r        <= acc_nxt;
        held_r       <= held_nxt;
        bytes_done_r <= bytes_done_nxt;
        error_seen_r <= error_seen_nxt;
        out_valid_r  <= has_result;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_code;
      in_eot_r  <= in_end_of_text;
    end
    if (proc && has_result) begin
      out_kind_r  <= out_kind_nxt;
      out_data_r  <= out_data_nxt;
      out_count_r <= out_count_nxt;
      out_final_r <= out_final_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data_byte  = out_data_r;
  assign out_byte_count = out_count_r;
  assign out_final_res  = out_final_r;

  // an end request leaves the string state cleared
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_eot_r) |=> (bytes_done_r == 8'd0 && held_r == '0 && !error_seen_r))
    else $error("string state not cleared after end request");

  // after an error no byte is counted until the end request
  a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && error_seen_r && !in_eot_r) |=>
      (bytes_done_r == $past(bytes_done_r) && !out_valid_r))
    else $error("activity after error");

  // a byte result always bumps the count
  a_byte_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && has_result && !in_eot_r) |=> (bytes_done_r == $past(bytes_done_r) + 8'd1))
    else $error("byte result without count update");

  // final flag marks exactly the status results
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_final_r == (out_kind_r != b32d_pkg::KIND_BYTE)))
    else $error("final flag and kind disagree");

endmodule

/* tb/testbench.sv */
// Testbench for base32_stream_decoder: directed and random character streams against a predictor.
`timescale 1ns / 1ps

module testbench;
  import b32d_pkg::*;

  // two-stage pipe; an idle margin before a limit write or the end
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned STUCK_LIMIT  = 2000;

  typedef enum logic [1:0] {CLS_DIGIT, CLS_SKIP, CLS_BAD} char_class_e;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              eot;
  } char_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        data_byte;
    logic [7:0]        byte_count;
    logic              final_res;
  } dec_result_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              cfg_wr_en      = 1'b0;
  logic [7:0]        cfg_wr_data    = '0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] in_char_code   = '0;
  logic              in_end_of_text = 1'b0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [7:0]        out_data_byte;
  logic [7:0]        out_byte_count;
  logic              out_final_res;

  // requests waiting to be driven, and results waiting to come out
  char_req_t   char_q[$];
  dec_result_t result_q[$];

  // predictor copy of the string state and the byte limit
  logic [ACC_W-1:0] acc_bits   = '0;
  logic [3:0]       held_cnt   = '0;
  logic [7:0]       bytes_out  = '0;
  logic             bad_seen   = 1'b0;
  logic [7:0]       byte_limit = LIMIT_RESET;

  int mismatches   = 0;
  int stuck_cycles = 0;
  int items_added  = 0;
  bit send_gaps    = 1'b0;
  int stall_pct    = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int ready_tick   = 0;

  base32_stream_decoder dut (.*);

  always #10 clk = ~clk;

  // Classify one character; val holds the 5-bit digit for CLS_DIGIT.
  function automatic char_class_e classify_char(input logic [CHAR_W-1:0] c,
                                                output logic [DIGIT_W-1:0] val);
    logic [CHAR_W-1:0] m;
    val = '0;
    m = c;
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_DASH: return CLS_SKIP;
      CH_ZERO:  m = CH_UP_O;   // typo fixes
      CH_ONE:   m = CH_UP_L;
      CH_EIGHT: m = CH_UP_B;
      default: ;
    endcase
    // 0x41..0x5A and 0x61..0x7A share the low five bits 1..26
    if ((m[7:5] == 3'b010 || m[7:5] == 3'b011) && m[4:0] >= 5'd1 && m[4:0] <= 5'd26) begin
      val = m[4:0] - 5'd1;
      return CLS_DIGIT;
    end
    if (m >= CH_TWO && m <= CH_SEVEN) begin
      val = m[4:0] - CH_TWO[4:0] + 5'd26;
      return CLS_DIGIT;
    end
    return CLS_BAD;
  endfunction

  // Advance the predicted string state by one accepted request.
  // Returns 1 when the request produces a result.
  function automatic bit predict_result(input char_req_t rq, output dec_result_t res);
    char_class_e       cls;
    logic [DIGIT_W-1:0] val;
    logic [ACC_W-1:0]  nxt;
    logic [3:0]        held_n;
    res = '0;
    if (rq.eot) begin
      res.final_res = 1'b1;
      if (bad_seen) begin
        res.kind = KIND_ERROR;
      end else begin
        res.kind = KIND_COUNT;
        res.byte_count = bytes_out;
      end
      acc_bits  = '0;
      held_cnt  = '0;
      bytes_out = '0;
      bad_seen  = 1'b0;
      return 1'b1;
    end
    // limit reached or error latched: drop silently, even bad characters
    if (bad_seen || bytes_out >= byte_limit) return 1'b0;
    cls = classify_char(rq.code, val);
    if (cls == CLS_SKIP) return 1'b0;
    if (cls == CLS_BAD) begin
      bad_seen = 1'b1;
      return 1'b0;
    end
    nxt = {acc_bits[ACC_W-6:0], val};
    held_n = held_cnt + 4'd5;
    if (held_n < 4'd8) begin
      acc_bits = nxt;
      held_cnt = held_n;
      return 1'b0;
    end
    held_n = held_n - 4'd8;
    res.kind = KIND_BYTE;
    res.data_byte = 8'(nxt >> held_n);
    acc_bits  = nxt & ((12'd1 << held_n) - 12'd1);
    held_cnt  = held_n;
    bytes_out = bytes_out + 8'd1;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_char(input logic [CHAR_W-1:0] c, input logic eot);
    char_req_t rq;
    rq.code = c;
    rq.eot  = eot;
    char_q.push_back(rq);
    items_added++;
  endtask

  function automatic logic [CHAR_W-1:0] valid_char();
    case ($urandom_range(0, 3))
      0: return CH_UP_A + 8'($urandom_range(0, 25));
      1: return CH_LO_A + 8'($urandom_range(0, 25));
      2: return CH_TWO + 8'($urandom_range(0, 5));
      default: begin
        case ($urandom_range(0, 2))
          0: return CH_ZERO;
          1: return CH_ONE;
          default: return CH_EIGHT;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] skip_char();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_LF;
      default: return CH_DASH;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] bad_char();
    logic [CHAR_W-1:0]  c;
    logic [DIGIT_W-1:0] dummy;
    do c = 8'($urandom_range(0, 255)); while (classify_char(c, dummy) != CLS_BAD);
    return c;
  endfunction

  // One string plus its end request; broken strings get one bad character inserted.
  task automatic send_string(input int len, input int noise_pct, input bit broken);
    int bad_at;
    int r;
    bad_at = broken ? $urandom_range(0, len) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == bad_at) add_char(bad_char(), 1'b0);
      r = $urandom_range(0, 99);
      if (r < noise_pct) add_char(8'($urandom_range(0, 255)), 1'b0);
      else if (r < noise_pct + 12) add_char(skip_char(), 1'b0);
      else add_char(valid_char(), 1'b0);
    end
    if (bad_at == len) add_char(bad_char(), 1'b0);
    add_char(8'($urandom_range(0, 255)), 1'b1);   // char code is don't-care here
  endtask

  task automatic run_random(input int n_items);
    int stop_at;
    int len;
    stop_at = items_added + n_items;
    while (items_added < stop_at) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 24);
      send_string(len, ($urandom_range(0, 9) == 0) ? 30 : 2, $urandom_range(0, 4) == 0);
    end
  endtask

  // Sampled on the falling edge so the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk); while (char_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    byte_limit   = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Request driver: pops the pending queue, predicts on each accepted request,
  // and inserts random gaps between bursts when send_gaps is set.
  always @(posedge clk) begin
    char_req_t   cur;
    char_req_t   nxt;
    dec_result_t res;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        cur.code = in_char_code;
        cur.eot  = in_end_of_text;
        if (predict_result(cur, res)) result_q.push_back(res);
      end
      // slot is free when nothing is up or the current request just went in
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_q.size() != 0) begin
          nxt = char_q.pop_front();
          in_valid       <= 1'b1;
          in_char_code   <= nxt.code;
          in_end_of_text <= nxt.eot;
          if (burst_left > 0) begin
            burst_left--;
          end else if (send_gaps) begin
            burst_left = $urandom_range(0, 24);
            gap_left   = $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure: stalls only while bit 6 of ready_tick is set,
  // so long stall-free stretches come up in each phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_tick <= 0;
    end else begin
      ready_tick <= ready_tick + 1;
      if (!ready_tick[6] || stall_pct == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    dec_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %0h count %0d final %0b",
                                  out_kind, out_data_byte, out_byte_count, out_final_res));
      end else begin
        want = result_q.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", out_kind, want.kind));
        if (out_data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte got %0h want %0h",
                                    out_data_byte, want.data_byte));
        if (out_byte_count !== want.byte_count)
          report_mismatch($sformatf("byte_count got %0d want %0d",
                                    out_byte_count, want.byte_count));
        if (out_final_res !== want.final_res)
          report_mismatch($sformatf("final_res got %0b want %0b",
                                    out_final_res, want.final_res));
      end
    end
  end

  // Watchdog: too long without any handshake on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit of 10, no idling: every digit class, every skip character,
    // the typo digits, an error string and an empty string.
    add_char(CH_UP_A, 1'b0);
    add_char(CH_SPACE, 1'b0);
    add_char(CH_UP_Z, 1'b0);
    add_char(CH_LO_A, 1'b0);
    add_char(CH_TAB, 1'b0);
    add_char(CH_LO_Z, 1'b0);
    add_char(CH_TWO, 1'b0);
    add_char(CH_CR, 1'b0);
    add_char(CH_SEVEN, 1'b0);
    add_char(CH_LF, 1'b0);
    add_char(CH_ZERO, 1'b0);
    add_char(CH_DASH, 1'b0);
    add_char(CH_ONE, 1'b0);
    add_char(CH_EIGHT, 1'b0);     // leftover bits dropped at the end
    add_char(8'h00, 1'b1);
    add_char(CH_UP_A, 1'b0);
    add_char(CH_UP_B, 1'b0);      // one byte goes out before the error
    add_char(8'hFF, 1'b0);
    add_char(CH_UP_O, 1'b0);
    add_char(8'hFF, 1'b1);
    add_char(8'h80, 1'b1);        // empty string
    add_char(8'h00, 1'b0);        // code zero is invalid
    add_char(8'h7F, 1'b1);

    // Limit 0: nothing decoded, nothing checked, count stays zero.
    write_limit(8'd0);
    send_gaps = 1'b1;
    stall_pct = 30;
    add_char(bad_char(), 1'b0);
    add_char(CH_UP_A, 1'b1);
    run_random(60);

    // Limit 255: one long string runs into the limit, then a bad character
    // must be dropped without raising an error. 420 digits carry 262 bytes.
    write_limit(8'd255);
    send_gaps = 1'b0;
    stall_pct = 50;
    for (int i = 0; i < 420; i++) begin
      if ($urandom_range(0, 19) == 0) add_char(skip_char(), 1'b0);
      add_char(valid_char(), 1'b0);
    end
    add_char(bad_char(), 1'b0);
    add_char(CH_UP_Z, 1'b1);
    run_random(100);

    // Limit 1: a bad character right after the only byte is ignored.
    write_limit(8'd1);
    send_gaps = 1'b1;
    stall_pct = 0;
    add_char(CH_SEVEN, 1'b0);
    add_char(CH_SEVEN, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(CH_UP_A, 1'b1);
    run_random(150);

    // Mostly small limits so strings hit them often, sometimes any value.
    for (int p = 0; p < 5; p++) begin
      write_limit(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(2, 16)));
      send_gaps = p[0];
      stall_pct = $urandom_range(0, 60);
      run_random(110);
    end

    write_limit(LIMIT_RESET);
    send_gaps = 1'b1;
    stall_pct = 40;
    run_random(100);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
src/b32d_pkg.sv
src/base32_stream_decoder.sv
tb/testbench.sv
